FILE: hdl/can_transport_reassembler_unit_macros.svh
// Assertion macros for the CAN transport reassembler.
`ifndef CAN_TRANSPORT_REASSEMBLER_UNIT_MACROS_SVH
`define CAN_TRANSPORT_REASSEMBLER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define CANTR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("reassembler check failed");
`define CANTR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("reassembler check failed");
`else
`define CANTR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define CANTR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/cantr_pkg.sv
// Shared types and constants for the CAN transport reassembler.
package cantr_pkg;

    localparam int BYTE_W  = 8;
    localparam int FLEN_W  = 7;
    localparam int SIZE_W  = 14;
    localparam int SEQ_W   = 6;
    localparam int CIDX_W  = 1;
    localparam int CDATA_W = 14;

    localparam int FRAME_BYTES_MAX_DEFAULT = 64;
    localparam logic [FLEN_W-1:0] FRAME_BYTES_MIN   = 7'd8;
    localparam logic [FLEN_W-1:0] FRAME_BYTES_RESET = 7'd8;
    localparam logic [SIZE_W-1:0] MSG_LIMIT_RESET   = 14'd4095;
    localparam logic [FLEN_W-1:0] POS_SAT           = 7'd127;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_FRAME_BYTES   = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_MESSAGE_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        FT_SINGLE  = 2'd0,
        FT_FIRST   = 2'd1,
        FT_CONSEC  = 2'd2,
        FT_UNKNOWN = 2'd3
    } t_ftype;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic [FLEN_W-1:0] frame_len;
        logic              frame_start;
    } t_item;

    typedef struct packed {
        logic              receiving;
        logic [SIZE_W-1:0] message_size;
        logic [SIZE_W-1:0] received_count;
        logic [SIZE_W-1:0] frame_base;
        logic [SEQ_W-1:0]  sequence_expected;
        logic [FLEN_W-1:0] byte_position;
        t_ftype            frame_type;
        logic              frame_accepted;
        logic [SEQ_W-1:0]  size_high_bits;
        logic [FLEN_W-1:0] frame_take;
        logic [FLEN_W-1:0] frame_length;
    } t_state;

    typedef struct packed {
        logic              store_valid;
        logic [SIZE_W-1:0] store_addr;
        logic [BYTE_W-1:0] store_byte;
        logic              msg_done;
        logic [SIZE_W-1:0] msg_size;
        logic              frame_reject;
    } t_result;

endpackage

FILE: hdl/cantr_if.sv
// Channel interfaces: frame bytes in, buffer writes out, register writes.
interface cantr_in_if;
    logic                           valid;
    logic                           ready;
    logic [cantr_pkg::BYTE_W-1:0]   frame_byte;
    logic [cantr_pkg::FLEN_W-1:0]   frame_len;
    logic                           frame_start;
    modport source (output valid, frame_byte, frame_len, frame_start, input ready);
    modport sink   (input valid, frame_byte, frame_len, frame_start, output ready);
endinterface

interface cantr_out_if;
    logic                           valid;
    logic                           ready;
    logic                           store_valid;
    logic [cantr_pkg::SIZE_W-1:0]   store_addr;
    logic [cantr_pkg::BYTE_W-1:0]   store_byte;
    logic                           msg_done;
    logic [cantr_pkg::SIZE_W-1:0]   msg_size;
    logic                           frame_reject;
    modport source (output valid, store_valid, store_addr, store_byte, msg_done, msg_size,
                    frame_reject, input ready);
    modport sink   (input valid, store_valid, store_addr, store_byte, msg_done, msg_size,
                    frame_reject, output ready);
endinterface

interface cantr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cantr_pkg::CIDX_W-1:0]   reg_index;
    logic [cantr_pkg::CDATA_W-1:0]  wr_data;
    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

FILE: hdl/cantr_step.sv
// Per-byte next-state and result logic of the reassembler.
module cantr_step #(
    parameter int MAX_FRAME_BYTES = cantr_pkg::FRAME_BYTES_MAX_DEFAULT
) (
    input  cantr_pkg::t_item                  i_item,
    input  cantr_pkg::t_state                 i_state,
    input  logic [cantr_pkg::FLEN_W-1:0]      i_frame_bytes,
    input  logic [cantr_pkg::SIZE_W-1:0]      i_message_limit,
    output cantr_pkg::t_state                 o_state,
    output cantr_pkg::t_result                o_result
);
    import cantr_pkg::*;

    localparam logic [FLEN_W-1:0] FB_MAX = FLEN_W'(MAX_FRAME_BYTES);

    logic [FLEN_W-1:0] fb;
    logic [SEQ_W-1:0]  low6;
    logic [SIZE_W-1:0] ff_size;
    logic [SIZE_W-1:0] remain;
    logic              remain_fits;
    logic [FLEN_W-1:0] cf_take;
    logic              active;
    t_state            n;
    t_result           res;

    // frame size register saturated to the supported range
    always_comb begin
        if (i_frame_bytes < FRAME_BYTES_MIN) begin
            fb = FRAME_BYTES_MIN;
        end else if (i_frame_bytes > FB_MAX) begin
            fb = FB_MAX;
        end else begin
            fb = i_frame_bytes;
        end
    end

    assign low6        = i_item.frame_byte[SEQ_W-1:0];
    assign ff_size     = {i_state.size_high_bits, i_item.frame_byte};
    assign remain      = i_state.message_size - i_state.received_count;
    assign remain_fits = (remain < SIZE_W'(fb));
    assign cf_take     = remain_fits ? remain[FLEN_W-1:0] : (fb - 7'd1);

    always_comb begin
        n   = i_state;
        res = '0;
        if (i_item.frame_start) begin
            n.frame_length   = i_item.frame_len;
            n.byte_position  = '0;
            n.frame_accepted = 1'b0;
            n.frame_take     = '0;
            n.frame_type     = t_ftype'(i_item.frame_byte[BYTE_W-1:BYTE_W-2]);
        end
        active = (i_item.frame_start || (n.byte_position != '0))
                 && (n.byte_position < n.frame_length);
        if (active) begin
            if (n.byte_position == '0) begin
                case (n.frame_type)
                    FT_SINGLE: begin
                        n.message_size = SIZE_W'(low6);
                        if ((SIZE_W'(low6) > i_message_limit) || (FLEN_W'(low6) >= fb)
                            || (FLEN_W'(low6) >= n.frame_length)) begin
                            res.frame_reject = 1'b1;
                        end else begin
                            n.frame_accepted = 1'b1;
                            n.frame_take     = FLEN_W'(low6);
                            n.receiving      = 1'b0;
                            res.msg_done     = (low6 == '0);
                        end
                    end
                    FT_FIRST: begin
                        n.size_high_bits = low6;
                        res.frame_reject = (n.frame_length < 7'd2);
                    end
                    FT_CONSEC: begin
                        if (!i_state.receiving) begin
                            res.frame_reject = 1'b1;
                        end else if (low6 != i_state.sequence_expected) begin
                            n.receiving      = 1'b0;
                            res.frame_reject = 1'b1;
                        end else if (cf_take >= n.frame_length) begin
                            n.receiving      = 1'b0;
                            res.frame_reject = 1'b1;
                        end else begin
                            n.frame_accepted    = 1'b1;
                            n.frame_take        = cf_take;
                            n.frame_base        = i_state.received_count;
                            n.received_count    = i_state.received_count + SIZE_W'(cf_take);
                            n.sequence_expected = i_state.sequence_expected + 6'd1;
                            // whole remainder fits: message complete
                            if (remain_fits) begin
                                n.receiving  = 1'b0;
                                res.msg_done = (cf_take == '0);
                            end
                        end
                    end
                    default: begin
                        n.receiving      = 1'b0;
                        res.frame_reject = 1'b1;
                    end
                endcase
            end else if ((n.frame_type == FT_FIRST) && (n.byte_position == 7'd1)) begin
                n.message_size = ff_size;
                if ((ff_size > i_message_limit) || (ff_size < SIZE_W'(fb))
                    || (n.frame_length < fb)) begin
                    res.frame_reject = 1'b1;
                end else begin
                    n.frame_accepted    = 1'b1;
                    n.frame_take        = fb - 7'd2;
                    n.received_count    = SIZE_W'(fb - 7'd2);
                    n.sequence_expected = 6'd1;
                    n.receiving         = 1'b1;
                end
            end else if (n.frame_accepted) begin
                if (n.frame_type == FT_FIRST) begin
                    if ((n.byte_position - 7'd2) < n.frame_take) begin
                        res.store_valid = 1'b1;
                        res.store_addr  = SIZE_W'(n.byte_position - 7'd2);
                        res.store_byte  = i_item.frame_byte;
                    end
                end else if (n.byte_position <= n.frame_take) begin
                    res.store_valid = 1'b1;
                    res.store_byte  = i_item.frame_byte;
                    if (n.frame_type == FT_SINGLE) begin
                        res.store_addr = SIZE_W'(n.byte_position - 7'd1);
                        res.msg_done   = (n.byte_position == n.frame_take);
                    end else begin
                        res.store_addr = n.frame_base + SIZE_W'(n.byte_position - 7'd1);
                        res.msg_done   = (n.byte_position == n.frame_take) && !n.receiving;
                    end
                end
            end
            if (n.byte_position < POS_SAT) begin
                n.byte_position = n.byte_position + 7'd1;
            end
        end
        res.msg_size = res.msg_done ? n.message_size : '0;
    end

    assign o_state  = n;
    assign o_result = res;

endmodule

FILE: hdl/cantr_oreg.sv
// Output register holding one result beat until the sink takes it.
module cantr_oreg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  cantr_pkg::t_result  i_result,
    output logic                o_can_load,
    cantr_out_if.source         o_out
);
    import cantr_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.store_valid  = r_result.store_valid;
    assign o_out.store_addr   = r_result.store_addr;
    assign o_out.store_byte   = r_result.store_byte;
    assign o_out.msg_done     = r_result.msg_done;
    assign o_out.msg_size     = r_result.msg_size;
    assign o_out.frame_reject = r_result.frame_reject;

endmodule

FILE: hdl/can_transport_reassembler_unit.sv
// Latency: a result beat appears in the cycle after its frame byte is taken.
// Throughput: one frame byte per cycle; the output register is the only stage,
// and the byte channel stalls only while that register holds an untaken beat.
// Reassembly state updates in the same edge that accepts the byte.
// Reset (synchronous, active low) clears reassembly state and the output valid,
// and loads frame_bytes = 8 and message_limit = 4095.
`include "can_transport_reassembler_unit_macros.svh"

module can_transport_reassembler_unit #(
    parameter int MAX_FRAME_BYTES = cantr_pkg::FRAME_BYTES_MAX_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cantr_in_if.sink      i_frame,
    cantr_cfg_if.sink     i_cfg,
    cantr_out_if.source   o_result
);
    import cantr_pkg::*;

    // configuration registers
    logic [FLEN_W-1:0] r_frame_bytes;
    logic [SIZE_W-1:0] r_message_limit;

    // reassembly context
    t_state  r_state;
    t_state  n_state;
    t_item   item;
    t_result step_res;
    logic    can_load;
    logic    accept;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bytes   <= FRAME_BYTES_RESET;
            r_message_limit <= MSG_LIMIT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                CFG_FRAME_BYTES:   r_frame_bytes   <= i_cfg.wr_data[FLEN_W-1:0];
                CFG_MESSAGE_LIMIT: r_message_limit <= i_cfg.wr_data[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // a byte is taken whenever the output register can accept its beat
    assign i_frame.ready = can_load;
    assign accept        = i_frame.valid && can_load;

    assign item.frame_byte  = i_frame.frame_byte;
    assign item.frame_len   = i_frame.frame_len;
    assign item.frame_start = i_frame.frame_start;

    cantr_step #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_step (
        .i_item          (item),
        .i_state         (r_state),
        .i_frame_bytes   (r_frame_bytes),
        .i_message_limit (r_message_limit),
        .o_state         (n_state),
        .o_result        (step_res)
    );

    // context moves on only with an accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    cantr_oreg u_oreg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (i_frame.valid),
        .i_result   (step_res),
        .o_can_load (can_load),
        .o_out      (o_result)
    );

    // every accepted byte yields a beat on the next cycle
    `CANTR_ASSERT_NEXT(a_beat_follows, i_clk, i_rst_n, accept, o_result.valid)
    // a dropped frame never stores or completes on the judging byte
    `CANTR_ASSERT_IMPL(a_reject_excl, i_clk, i_rst_n,
        o_result.valid && o_result.frame_reject,
        !o_result.store_valid && !o_result.msg_done)
    // idle store lanes are zeroed
    `CANTR_ASSERT_IMPL(a_store_zero, i_clk, i_rst_n,
        o_result.valid && !o_result.store_valid,
        (o_result.store_addr == '0) && (o_result.store_byte == '0))
    // a first frame in flight always has at least its two header bytes
    `CANTR_ASSERT_IMPL(a_ff_take, i_clk, i_rst_n,
        r_state.frame_accepted && (r_state.frame_type == FT_FIRST),
        r_state.byte_position >= 7'd2)

endmodule

FILE: test/can_transport_reassembler_unit_test.sv
// Self-checking testbench for the CAN transport reassembler, directed and random frame streams against a model.
module can_transport_reassembler_unit_test;
    import cantr_pkg::*;

    localparam int MAX_FB      = 64;
    localparam int CYCLE_LIMIT = 100000;
    localparam int PHASE_ITEMS = 290;
    localparam int ROUGH_PCT   = 20;
    localparam int HOLD_CYCLES = 200;
    localparam int PRINT_CAP   = 100;

    logic i_clk;
    logic i_rst_n;

    cantr_in_if  frm ();
    cantr_out_if res ();
    cantr_cfg_if cfg ();

    can_transport_reassembler_unit #(.MAX_FRAME_BYTES(MAX_FB)) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frm),
        .i_cfg    (cfg),
        .o_result (res)
    );

    // 8 time unit clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Reassembly model: register copies and reception state
    // ---------------------------------------------------------------
    logic [FLEN_W-1:0] reg_fb;       // frame_bytes as last written
    logic [SIZE_W-1:0] reg_limit;    // message_limit
    logic              rx_active;
    logic [SIZE_W-1:0] msg_len;
    logic [SIZE_W-1:0] got_len;
    logic [SEQ_W-1:0]  seq_next;
    logic [FLEN_W-1:0] byte_pos;
    t_ftype            cur_type;
    logic              cur_ok;
    logic [SEQ_W-1:0]  len_hi;
    logic [FLEN_W-1:0] cur_take;
    logic [FLEN_W-1:0] cur_flen;

    // frame bytes waiting for the driver, result beats waiting for the DUT
    t_item   byte_feed[$];
    t_result due_beats[$];

    int queued;       // frame bytes handed to the driver so far
    int beats_in;     // frame bytes taken by the DUT
    int beats_out;    // result beats taken from the DUT
    int fail_count;
    int cycle_count;
    int gap_pct;      // idle chance per cycle on both sides, in percent
    logic rx_hold;    // long receiver hold-off
    logic in_taken;   // byte beat accepted at the last rising edge

    t_item   nxt_byte;
    t_item   seen_byte;
    t_result want;

    // Effective frame size: register saturated into the legal range
    function automatic int frame_cap();
        if (reg_fb < FRAME_BYTES_MIN) return FRAME_BYTES_MIN;
        if (reg_fb > MAX_FB) return MAX_FB;
        return reg_fb;
    endfunction

    // One frame byte in, one result beat out; state moves at judgement
    function automatic t_result reassemble(input t_item it);
        t_result r;
        int unsigned fb, pos, flen, sz, take;
        logic [SIZE_W-1:0] gap;
        r = '0;
        fb = frame_cap();
        if (it.frame_start) begin
            cur_flen = it.frame_len;
            byte_pos = '0;
            cur_ok   = 1'b0;
            cur_take = '0;
            cur_type = t_ftype'(it.frame_byte[7:6]);
        end
        pos  = byte_pos;
        flen = cur_flen;
        if ((it.frame_start || pos != 0) && pos < flen) begin
            if (pos == 0) begin
                case (cur_type)
                    FT_SINGLE: begin
                        // size always lands in msg_len, even on a reject
                        sz = it.frame_byte[5:0];
                        msg_len = sz[SIZE_W-1:0];
                        if (sz > reg_limit || sz > fb - 1 || sz > flen - 1) begin
                            r.frame_reject = 1'b1;
                        end else begin
                            cur_ok    = 1'b1;
                            cur_take  = sz[FLEN_W-1:0];
                            rx_active = 1'b0;
                            r.msg_done = (sz == 0);
                        end
                    end
                    FT_FIRST: begin
                        // judged on the second byte, unless there is none
                        len_hi = it.frame_byte[5:0];
                        r.frame_reject = (flen < 2);
                    end
                    FT_CONSEC: begin
                        if (!rx_active) begin
                            r.frame_reject = 1'b1;
                        end else if (it.frame_byte[5:0] != seq_next) begin
                            rx_active = 1'b0;
                            r.frame_reject = 1'b1;
                        end else begin
                            gap  = msg_len - got_len;
                            take = (gap > fb - 1) ? fb - 1 : gap;
                            if (flen - 1 < take) begin
                                rx_active = 1'b0;
                                r.frame_reject = 1'b1;
                            end else begin
                                cur_ok   = 1'b1;
                                cur_take = take[FLEN_W-1:0];
                                got_len  = got_len + take[SIZE_W-1:0];
                                seq_next = seq_next + 1'b1;
                                if (got_len == msg_len) begin
                                    rx_active = 1'b0;
                                    r.msg_done = (take == 0);
                                end
                            end
                        end
                    end
                    default: begin
                        rx_active = 1'b0;
                        r.frame_reject = 1'b1;
                    end
                endcase
            end else if (cur_type == FT_FIRST && pos == 1) begin
                msg_len = {len_hi, it.frame_byte};
                if (msg_len > reg_limit || msg_len < fb || flen < fb) begin
                    r.frame_reject = 1'b1;
                end else begin
                    cur_ok    = 1'b1;
                    cur_take  = FLEN_W'(fb - 2);
                    got_len   = SIZE_W'(fb - 2);
                    seq_next  = SEQ_W'(1);
                    rx_active = 1'b1;
                end
            end else if (cur_ok) begin
                if (cur_type == FT_FIRST) begin
                    if (pos - 2 < cur_take) begin
                        r.store_valid = 1'b1;
                        r.store_addr  = SIZE_W'(pos - 2);
                        r.store_byte  = it.frame_byte;
                    end
                end else if (pos <= cur_take) begin
                    r.store_valid = 1'b1;
                    r.store_byte  = it.frame_byte;
                    if (cur_type == FT_SINGLE) begin
                        r.store_addr = SIZE_W'(pos - 1);
                        r.msg_done   = (pos == cur_take);
                    end else begin
                        // got_len already counts this frame's take
                        r.store_addr = SIZE_W'(got_len - cur_take + pos - 1);
                        r.msg_done   = (pos == cur_take) && !rx_active;
                    end
                end
            end
            if (byte_pos < POS_SAT) byte_pos = byte_pos + 1'b1;
        end
        if (r.msg_done) r.msg_size = msg_len;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp_val);
        if (fail_count < PRINT_CAP)
            $display("mismatch on %s at beat %0d: got 0x%0h, wanted 0x%0h",
                     what, beats_out, got, exp_val);
        fail_count++;
    endtask

    // ---------------------------------------------------------------
    // Stimulus building
    // ---------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b, input int flen, input bit first);
        t_item it;
        it.frame_byte  = b;
        it.frame_len   = FLEN_W'(flen);
        it.frame_start = first;
        byte_feed.push_back(it);
        queued++;
    endtask

    task automatic send_frame(input logic [7:0] body[$], input int flen);
        foreach (body[i]) queue_byte(body[i], flen, i == 0);
    endtask

    // Mostly exact frame lengths, sometimes padded out
    function automatic int pad_len(input int need);
        return ($urandom_range(3) == 0) ? $urandom_range(MAX_FB, need) : need;
    endfunction

    // Pad a frame to its length, optionally spoil it, then queue it
    task automatic finish_frame(input logic [7:0] body[$], input int flen, input bit rough);
        int n;
        while (body.size() < flen) body.push_back(8'($urandom));
        if (rough) begin
            case ($urandom_range(6))
                0: body[0] = body[0] ^ 8'h01;          // sequence or size one off
                1: begin                               // frame one byte short
                    if (flen > 1) flen--;
                    while (body.size() > flen) void'(body.pop_back());
                end
                2: begin                               // cut short by the next start
                    n = $urandom_range(body.size(), 1);
                    while (body.size() > n) void'(body.pop_back());
                end
                3: begin                               // failing first frame mid-message
                    queue_byte(8'h7F, 2, 1'b1);
                    queue_byte(8'hFF, 2, 1'b0);
                end
                4: queue_byte(8'h3F, 1, 1'b1);         // failing single frame
                5: queue_byte(8'hC0, 1, 1'b1);         // unknown type drops reception
                default: begin                         // stray bytes past the frame end
                    repeat ($urandom_range(3, 1)) body.push_back(8'($urandom));
                end
            endcase
        end
        send_frame(body, flen);
    endtask

    // A message of the given size, in single or segmented form, spoilt at random when rough
    task automatic push_message(input int size, input bit rough);
        logic [7:0] body[$];
        int fb, left, take, seq;
        fb = frame_cap();
        if (size < fb) begin
            body.push_back({2'b00, size[5:0]});
            repeat (size) body.push_back(8'($urandom));
            finish_frame(body, pad_len(size + 1), rough);
            return;
        end
        body.push_back({2'b01, size[13:8]});
        body.push_back(size[7:0]);
        repeat (fb - 2) body.push_back(8'($urandom));
        finish_frame(body, ($urandom_range(3) == 0) ? $urandom_range(MAX_FB, fb) : fb, 1'b0);
        // over the limit, or too long to be worth streaming: first frame only
        if (size > reg_limit || size > 300) return;
        left = size - (fb - 2);
        seq  = 1;
        while (left > 0) begin
            take = (left < fb - 1) ? left : fb - 1;
            body = {};
            body.push_back({2'b10, seq[5:0]});
            repeat (take) body.push_back(8'($urandom));
            finish_frame(body, pad_len(take + 1), rough && $urandom_range(7) == 0);
            left -= take;
            seq++;
        end
    endtask

    // Junk between messages
    task automatic push_noise();
        logic [7:0] body[$];
        int flen, n;
        flen = $urandom_range(MAX_FB, 1);
        case ($urandom_range(4))
            0: repeat ($urandom_range(3, 1))
                   queue_byte(8'($urandom), $urandom_range(MAX_FB, 0), 1'b0);
            1: queue_byte(8'($urandom), 0, 1'b1);      // zero-length frame
            2: body.push_back({2'b11, 6'($urandom)});
            3: body.push_back({2'b10, 6'($urandom)});
            default: begin
                body.push_back(8'($urandom));
                flen = $urandom_range(MAX_FB, 0);
            end
        endcase
        if (body.size() != 0) begin
            n = $urandom_range(flen + 2, 1);
            while (body.size() < n) body.push_back(8'($urandom));
            send_frame(body, flen);
        end
    endtask

    // Wait until every byte is taken and every beat has come back
    task automatic settle();
        do @(negedge i_clk); while (beats_in != queued || due_beats.size() != 0);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic run_phase(input int count);
        int stop, fb, size, pick;
        stop = queued + count;
        while (queued < stop) begin
            fb = frame_cap();
            if ($urandom_range(9) == 0) push_noise();
            pick = $urandom_range(99);
            if (pick < 55)      size = $urandom_range(fb - 1, 0);
            else if (pick < 93) size = $urandom_range(3 * fb, fb);
            else                size = $urandom_range(16383, 0);
            push_message(size, $urandom_range(99) < ROUGH_PCT);
        end
        settle();
    endtask

    // Register write; only issued with the DUT idle
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
        @(negedge i_clk);
        cfg.valid     = 1'b1;
        cfg.reg_index = idx;
        cfg.wr_data   = data;
        do @(posedge i_clk); while (cfg.ready !== 1'b1);
        if (idx == CFG_FRAME_BYTES) reg_fb = data[FLEN_W-1:0];
        else                        reg_limit = data;
        @(negedge i_clk);
        cfg.valid = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Byte driver: holds each beat until taken, idles at random
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!frm.valid || in_taken) begin
                if (byte_feed.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    nxt_byte = byte_feed.pop_front();
                    frm.valid       <= 1'b1;
                    frm.frame_byte  <= nxt_byte.frame_byte;
                    frm.frame_len   <= nxt_byte.frame_len;
                    frm.frame_start <= nxt_byte.frame_start;
                end else begin
                    frm.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls plus the long hold-off
    always @(negedge i_clk) begin
        res.ready <= !rx_hold && ($urandom_range(99) >= gap_pct);
    end

    // Monitor: check result beats, predict from accepted byte beats
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && frm.valid && frm.ready;
        if (i_rst_n) begin
            if (res.valid && res.ready) begin
                beats_out++;
                if (due_beats.size() == 0) begin
                    report_mismatch("beat with nothing due", 1, 0);
                end else begin
                    want = due_beats.pop_front();
                    if (res.store_valid !== want.store_valid)
                        report_mismatch("store_valid", res.store_valid, want.store_valid);
                    if (res.store_addr !== want.store_addr)
                        report_mismatch("store_addr", res.store_addr, want.store_addr);
                    if (res.store_byte !== want.store_byte)
                        report_mismatch("store_byte", res.store_byte, want.store_byte);
                    if (res.msg_done !== want.msg_done)
                        report_mismatch("msg_done", res.msg_done, want.msg_done);
                    if (res.msg_size !== want.msg_size)
                        report_mismatch("msg_size", res.msg_size, want.msg_size);
                    if (res.frame_reject !== want.frame_reject)
                        report_mismatch("frame_reject", res.frame_reject, want.frame_reject);
                end
            end
            if (frm.valid && frm.ready) begin
                seen_byte.frame_byte  = frm.frame_byte;
                seen_byte.frame_len   = frm.frame_len;
                seen_byte.frame_start = frm.frame_start;
                due_beats.push_back(reassemble(seen_byte));
                beats_in++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Back-pressure: stall the results long enough for the byte side to back up
    initial begin
        rx_hold = 1'b0;
        wait (beats_in >= 700);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    // ---------------------------------------------------------------
    // Sequence: reset, directed corner cases, then random phases
    // ---------------------------------------------------------------
    initial begin
        frm.valid       = 1'b0;
        frm.frame_byte  = '0;
        frm.frame_len   = '0;
        frm.frame_start = 1'b0;
        cfg.valid       = 1'b0;
        cfg.reg_index   = CFG_FRAME_BYTES;
        cfg.wr_data     = '0;
        res.ready       = 1'b0;
        in_taken        = 1'b0;
        queued          = 0;
        beats_in        = 0;
        beats_out       = 0;
        fail_count      = 0;
        cycle_count     = 0;
        gap_pct         = 8;
        reg_fb          = FRAME_BYTES_RESET;
        reg_limit       = MSG_LIMIT_RESET;
        rx_active       = 1'b0;
        msg_len         = '0;
        got_len         = '0;
        seq_next        = '0;
        byte_pos        = '0;
        cur_type        = FT_SINGLE;
        cur_ok          = 1'b0;
        len_hi          = '0;
        cur_take        = '0;
        cur_flen        = '0;

        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // stray byte before any frame has started
        queue_byte(8'hFF, 64, 1'b0);
        // zero-length frame is skipped silently, its tail too
        queue_byte(8'h03, 0, 1'b1);
        queue_byte(8'h55, 0, 1'b0);
        // consecutive frame with nothing in progress
        queue_byte(8'h81, 2, 1'b1);
        queue_byte(8'hAA, 2, 1'b0);
        // unknown type while idle
        queue_byte(8'hFF, 1, 1'b1);
        // first frame only one byte long: dropped on its header
        queue_byte(8'h40, 1, 1'b1);
        // empty single frame completes on its header
        queue_byte(8'h00, 1, 1'b1);
        // largest classic single frame, payload at both extremes
        queue_byte(8'h07, 8, 1'b1);
        for (int k = 0; k < 7; k++) queue_byte((k % 2) ? 8'h00 : 8'hFF, 8, 1'b0);
        // single frame claiming more than its frame holds
        queue_byte(8'h05, 3, 1'b1);
        queue_byte(8'h11, 3, 1'b0);
        queue_byte(8'h22, 3, 1'b0);
        // first frame with every size bit set, past the limit
        queue_byte(8'h7F, 8, 1'b1);
        queue_byte(8'hFF, 8, 1'b0);
        settle();

        // reset settings: classic frames, default limit
        run_phase(PHASE_ITEMS);

        // FD frames and the largest limit, both sides streaming flat out
        write_reg(CFG_FRAME_BYTES, 14'd64);
        write_reg(CFG_MESSAGE_LIMIT, 14'h3FFF);
        @(posedge i_clk);
        gap_pct = 0;
        run_phase(PHASE_ITEMS);
        @(posedge i_clk);
        gap_pct = 8;

        // smallest limit: nearly everything is refused
        write_reg(CFG_FRAME_BYTES, 14'd8);
        write_reg(CFG_MESSAGE_LIMIT, 14'd1);
        run_phase(PHASE_ITEMS);

        // frame size below the floor saturates up to classic
        write_reg(CFG_FRAME_BYTES, 14'd0);
        write_reg(CFG_MESSAGE_LIMIT, 14'd100);
        run_phase(PHASE_ITEMS);

        // frame size above the ceiling saturates down to FD
        write_reg(CFG_FRAME_BYTES, 14'h3FFF);
        write_reg(CFG_MESSAGE_LIMIT, 14'd300);
        run_phase(PHASE_ITEMS);

        // odd frame size; upper data bits are dropped by the register
        write_reg(CFG_FRAME_BYTES, 14'h3F94);
        write_reg(CFG_MESSAGE_LIMIT, 14'd4095);
        run_phase(PHASE_ITEMS);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/cantr_pkg.sv
hdl/cantr_if.sv
hdl/cantr_step.sv
hdl/cantr_oreg.sv
hdl/can_transport_reassembler_unit.sv
test/can_transport_reassembler_unit_test.sv
